// ----- hw/rtl/multiturn_angle_unwrap_velocity_core_assert.svh -----
// assertion macros for the multiturn angle unwrap core
// expects clk and rst in the scope of each use
`ifndef MULTITURN_ANGLE_UNWRAP_VELOCITY_CORE_ASSERT_SVH
`define MULTITURN_ANGLE_UNWRAP_VELOCITY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MAUV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MAUV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAUV_ASSERT(lbl, prop, msg)
`define MAUV_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/mauv_pkg.sv -----
// shared types and codes for the multiturn angle unwrap core
// no dependencies
package mauv_pkg;

  localparam logic [1:0] OP_UPDATE     = 2'd0;
  localparam logic [1:0] OP_INVALIDATE = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;

  localparam int GAIN_W = 40;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        single_turn_position;
    logic               turns_given;
    logic signed [31:0] turns;
    logic               vel_given;
    logic signed [31:0] velocity_in;
  } sample_t;

  typedef struct packed {
    logic               accepted;
    logic signed [63:0] position_count;
    logic signed [31:0] velocity_out;
    logic               position_known;
    logic               data_fresh;
  } result_t;

  typedef struct packed {
    logic fire;
    logic load;
  } stage_ctl_t;

  // after the unwrap stage
  typedef struct packed {
    logic               accepted;
    logic signed [63:0] position_count;
    logic               position_known;
    logic               data_fresh;
    logic               vel_set;
    logic               vel_direct;
    logic signed [31:0] vel_value;
    logic               neg;
    logic [63:0]        mag;
  } unwrap_t;

  // after the product stage, velocity resolved
  typedef struct packed {
    logic               accepted;
    logic signed [63:0] position_count;
    logic               position_known;
    logic               data_fresh;
    logic               vel_set;
    logic signed [31:0] vel_value;
  } scaled_t;

endpackage

// ----- hw/rtl/multiturn_angle_unwrap_velocity_core.sv -----
// top level of the multiturn angle unwrap core with velocity estimate
// depends on mauv_pkg, mauv_unwrap, mauv_scale and the assertion header
//
//   channel  | signals                              | transaction
//   sample   | sample_valid, sample_stall, sample   | valid high, stall low
//   result   | result_valid, result_stall, result   | valid high, stall low
//   gain     | gain_valid, gain_ready, gain_data    | valid and ready high
//
// one sample per cycle while sample_stall is low; the result passes the unwrap, product and result registers
// the position state loop closes inside the unwrap stage
// stages: input register, unwrap, product, result register; each holds on stall
// synchronous reset empties the pipeline and zeroes state and gain
`include "multiturn_angle_unwrap_velocity_core_assert.svh"

module multiturn_angle_unwrap_velocity_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  mauv_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_stall,
  output mauv_pkg::result_t           result,
  input  logic                        gain_valid,
  output logic                        gain_ready,
  input  logic [mauv_pkg::GAIN_W-1:0] gain_data
);

  logic [mauv_pkg::GAIN_W-1:0] gain;
  mauv_pkg::sample_t           sample_q;
  logic                        v1;
  logic                        v2;
  logic                        v3;
  logic                        r1;
  logic                        r2;
  logic                        r3;
  logic                        r_out;
  logic signed [31:0]          velocity_held;
  mauv_pkg::stage_ctl_t        unwrap_ctl;
  mauv_pkg::unwrap_t           unwrap_stage;
  mauv_pkg::scaled_t           scaled;

  assign gain_ready   = 1'b1;
  assign r_out        = !result_valid || !result_stall;
  assign r3           = !v3 || r_out;
  assign r2           = !v2 || r3;
  assign r1           = !v1 || r2;
  assign sample_stall = !r1;

  assign unwrap_ctl.fire = v1 && r2;
  assign unwrap_ctl.load = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (gain_valid && gain_ready) begin
      gain <= gain_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= sample_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r_out) begin
        result_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      sample_q <= sample;
    end
  end

  mauv_unwrap u_unwrap (
    .clk       (clk),
    .rst       (rst),
    .ctl       (unwrap_ctl),
    .sample    (sample_q),
    .gain_zero (gain == '0),
    .stage     (unwrap_stage)
  );

  mauv_scale u_scale (
    .clk    (clk),
    .load   (r3),
    .stage  (unwrap_stage),
    .gain   (gain),
    .scaled (scaled)
  );

  // held velocity follows results in order
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_held <= '0;
    end else if (v3 && r_out && scaled.vel_set) begin
      velocity_held <= scaled.vel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (r_out) begin
      result.accepted       <= scaled.accepted;
      result.position_count <= scaled.position_count;
      result.velocity_out   <= scaled.vel_set ? scaled.vel_value : velocity_held;
      result.position_known <= scaled.position_known;
      result.data_fresh     <= scaled.data_fresh;
    end
  end

  `MAUV_ASSERT(a_accept_flags, result_valid && result.accepted |-> result.data_fresh && result.position_known, "accepted result without fresh known position")
  `MAUV_ASSERT(a_unknown_zero, result_valid && !result.position_known |-> result.position_count == 64'sd0 && result.velocity_out == 32'sd0 && !result.data_fresh, "unknown position with nonzero state")
  `MAUV_ASSERT(a_stall_full, sample_stall |-> v1 && v2 && v3 && result_valid, "sample stalled with room in the pipeline")
  `MAUV_ASSERT_RST(a_reset_empty, rst |=> !result_valid && !v1 && !v2 && !v3, "pipeline not empty after reset")

endmodule

// ----- hw/rtl/mauv_unwrap.sv -----
// unwrap stage: holds the position state and computes the position delta
// depends on mauv_pkg
module mauv_unwrap (
  input  logic                 clk,
  input  logic                 rst,
  input  mauv_pkg::stage_ctl_t ctl,
  input  mauv_pkg::sample_t    sample,
  input  logic                 gain_zero,
  output mauv_pkg::unwrap_t    stage
);

  logic [31:0]        last_single_turn;
  logic [63:0]        unwrapped_count;
  logic               known;
  logic               fresh;

  logic [31:0]        last_single_turn_next;
  logic [63:0]        unwrapped_count_next;
  logic               known_next;
  logic               fresh_next;

  logic [31:0]        angle;
  logic [31:0]        d32;
  logic [31:0]        d_mag;
  logic [63:0]        loaded;
  logic [63:0]        fwd;
  logic [63:0]        bwd;
  logic [63:0]        count_step;
  mauv_pkg::unwrap_t  stage_next;

  assign angle      = sample.single_turn_position;
  assign d32        = angle - last_single_turn;
  assign d_mag      = d32[31] ? (~d32 + 32'd1) : d32;
  assign loaded     = {sample.turns, angle};
  assign fwd        = loaded - unwrapped_count;
  assign bwd        = unwrapped_count - loaded;
  assign count_step = unwrapped_count + {{32{d32[31]}}, d32};

  always_comb begin
    last_single_turn_next = last_single_turn;
    unwrapped_count_next  = unwrapped_count;
    known_next            = known;
    fresh_next            = fresh;
    stage_next.accepted   = 1'b0;
    stage_next.vel_set    = 1'b0;
    stage_next.vel_direct = 1'b1;
    stage_next.vel_value  = '0;
    stage_next.neg        = 1'b0;
    stage_next.mag        = '0;
    unique case (sample.operation)
      mauv_pkg::OP_UPDATE: begin
        if (gain_zero) begin
          fresh_next = 1'b0;
        end else begin
          last_single_turn_next = angle;
          if (sample.turns_given) begin
            unwrapped_count_next = loaded;
          end else if (!known) begin
            unwrapped_count_next = {32'd0, angle};
          end else begin
            unwrapped_count_next = count_step;
          end
          if (known) begin
            if (sample.turns_given) begin
              stage_next.neg = fwd[63];
              stage_next.mag = fwd[63] ? bwd : fwd;
            end else begin
              stage_next.neg = d32[31];
              stage_next.mag = {32'd0, d_mag};
            end
          end
          known_next            = 1'b1;
          fresh_next            = 1'b1;
          stage_next.accepted   = 1'b1;
          stage_next.vel_set    = 1'b1;
          stage_next.vel_direct = sample.vel_given;
          stage_next.vel_value  = sample.velocity_in;
        end
      end
      mauv_pkg::OP_INVALIDATE: begin
        fresh_next = 1'b0;
      end
      mauv_pkg::OP_CLEAR: begin
        last_single_turn_next = '0;
        unwrapped_count_next  = '0;
        known_next            = 1'b0;
        fresh_next            = 1'b0;
        stage_next.vel_set    = 1'b1;
      end
      default: begin
      end
    endcase
    stage_next.position_count = unwrapped_count_next;
    stage_next.position_known = known_next;
    stage_next.data_fresh     = fresh_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_single_turn <= '0;
      unwrapped_count  <= '0;
      known            <= 1'b0;
      fresh            <= 1'b0;
    end else if (ctl.fire) begin
      last_single_turn <= last_single_turn_next;
      unwrapped_count  <= unwrapped_count_next;
      known            <= known_next;
      fresh            <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stage <= stage_next;
    end
  end

endmodule

// ----- hw/rtl/mauv_scale.sv -----
// velocity scaling: partial products, then floor shift and saturation, or the given velocity passed through
// depends on mauv_pkg
module mauv_scale (
  input  logic                        clk,
  input  logic                        load,
  input  mauv_pkg::unwrap_t           stage,
  input  logic [mauv_pkg::GAIN_W-1:0] gain,
  output mauv_pkg::scaled_t           scaled
);

  logic [31:0]        m0;
  logic [31:0]        m1;
  logic [31:0]        g0;
  logic [7:0]         g1;
  logic               m1_nz;
  logic [31:0]        hi_a;
  logic [31:0]        hi_b;

  logic               accepted;
  logic signed [63:0] position_count;
  logic               position_known;
  logic               data_fresh;
  logic               vel_set;
  logic               vel_direct;
  logic signed [31:0] vel_value;
  logic               neg;
  logic               huge;
  logic [63:0]        prod_lo;
  logic [63:0]        prod_hi;

  logic               frac;
  logic [64:0]        sum;
  logic [64:0]        sum_up;
  logic [31:0]        vel_calc;

  assign m0    = stage.mag[31:0];
  assign m1    = stage.mag[63:32];
  assign g0    = gain[31:0];
  assign g1    = gain[mauv_pkg::GAIN_W-1:32];
  assign m1_nz = (m1 != 32'd0);
  assign hi_a  = m1_nz ? m1 : m0;
  assign hi_b  = m1_nz ? g0 : {24'd0, g1};

  always_ff @(posedge clk) begin
    if (load) begin
      accepted       <= stage.accepted;
      position_count <= stage.position_count;
      position_known <= stage.position_known;
      data_fresh     <= stage.data_fresh;
      vel_set        <= stage.vel_set;
      vel_direct     <= stage.vel_direct;
      vel_value      <= stage.vel_value;
      neg            <= stage.neg;
      huge           <= m1_nz && (g1 != 8'd0);
      prod_lo        <= m0 * g0;
      prod_hi        <= hi_a * hi_b;
    end
  end

  assign frac   = (prod_lo[31:0] != 32'd0);
  assign sum    = {1'b0, prod_hi} + {33'd0, prod_lo[63:32]};
  assign sum_up = {1'b0, prod_hi} + {33'd0, prod_lo[63:32]} + {64'd0, frac};

  always_comb begin
    if (!neg) begin
      if (huge || (sum[64:31] != 34'd0)) begin
        vel_calc = 32'h7FFF_FFFF;
      end else begin
        vel_calc = sum[31:0];
      end
    end else begin
      if (huge || (sum_up[64:31] != 34'd0)) begin
        vel_calc = 32'h8000_0000;
      end else begin
        vel_calc = ~sum_up[31:0] + 32'd1;
      end
    end
  end

  assign scaled.accepted       = accepted;
  assign scaled.position_count = position_count;
  assign scaled.position_known = position_known;
  assign scaled.data_fresh     = data_fresh;
  assign scaled.vel_set        = vel_set;
  assign scaled.vel_value      = vel_direct ? vel_value : $signed(vel_calc);

endmodule
